// File: src/awrp_pkg.sv
// awrp_pkg: shared constants, types and state codes of the aging weighted random picker
// used by every file under src; depends on nothing
`timescale 1ns / 1ps

package awrp_pkg;

    // sizes
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_W       = 5;
    localparam int WEIGHT_W    = 32;
    localparam int SUM_W       = WEIGHT_W + IDX_W;
    localparam int RND_W       = 32;
    localparam int STEP_W      = $clog2(RND_W);

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    // request actions
    localparam logic ACT_RESTART = 1'b0;
    localparam logic ACT_PICK    = 1'b1;

    // control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_DONE
    } state_t;

    // weight memory read and write requests
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } ws_rd_req_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [WEIGHT_W-1:0] data;
    } ws_wr_req_t;

endpackage

// File: src/awrp_if.sv
// awrp_req_if and awrp_res_if: valid/ready channels of the picker
// payload widths come from awrp_pkg
`timescale 1ns / 1ps

interface awrp_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [awrp_pkg::RND_W-1:0]  random_value;

    modport source (output valid, output action, output random_value, input ready);
    modport sink   (input valid, input action, input random_value, output ready);
endinterface

interface awrp_res_if;
    logic                        valid;
    logic                        ready;
    logic [awrp_pkg::IDX_W-1:0]  chosen_index;

    modport source (output valid, output chosen_index, input ready);
    modport sink   (input valid, input chosen_index, output ready);
endinterface

// File: src/awrp_mod_unit.sv
// awrp_mod_unit: restoring remainder unit, one quotient bit per cycle
// depends on awrp_pkg for widths
`timescale 1ns / 1ps

module awrp_mod_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [awrp_pkg::RND_W-1:0]   dividend,
    input  logic [awrp_pkg::SUM_W-1:0]   divisor,
    output logic                         done,
    output logic [awrp_pkg::SUM_W-1:0]   remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [awrp_pkg::STEP_W-1:0]   cnt_reg;
    logic [awrp_pkg::SUM_W-1:0]    rem_reg;
    logic [awrp_pkg::SUM_W-1:0]    rem_next;
    logic [awrp_pkg::RND_W-1:0]    div_reg;
    logic [awrp_pkg::SUM_W-1:0]    dsr_reg;
    logic [awrp_pkg::SUM_W:0]      shifted;

    // one restoring step: bring down the next dividend bit, subtract when it fits
    always_comb
    begin
        shifted = {rem_reg, div_reg[awrp_pkg::RND_W-1]};
        if (shifted >= {1'b0, dsr_reg})
        begin
            rem_next = awrp_pkg::SUM_W'(shifted - {1'b0, dsr_reg});
        end
        else
        begin
            rem_next = shifted[awrp_pkg::SUM_W-1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= awrp_pkg::STEP_W'(awrp_pkg::RND_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            div_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            div_reg <= {div_reg[awrp_pkg::RND_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: src/awrp_weight_store.sv
// awrp_weight_store: weight memory with registered read
// per-entry valid bits make unwritten entries read as weight 1; depends on awrp_pkg
`timescale 1ns / 1ps

module awrp_weight_store
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            clear_all,
    input  awrp_pkg::ws_rd_req_t            rd,
    input  awrp_pkg::ws_wr_req_t            wr,
    output logic [awrp_pkg::WEIGHT_W-1:0]   rd_weight
);

    logic [awrp_pkg::WEIGHT_W-1:0]    weight_mem [awrp_pkg::MAX_ENTRIES];
    logic [awrp_pkg::MAX_ENTRIES-1:0] valid_reg;
    logic [awrp_pkg::WEIGHT_W-1:0]    rd_data_reg;
    logic                             rd_valid_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            weight_mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg  <= weight_mem[rd.addr];
            rd_valid_reg <= valid_reg[rd.addr];
        end
    end

    // written marks, cleared by reset and restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear_all)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_weight = rd_valid_reg ? rd_data_reg : awrp_pkg::WEIGHT_W'(1);

endmodule

// File: src/aging_weighted_random_picker.sv
// Aging weighted random picker. A restart request latches entry_count (0 taken as 1, values
// above 16 taken as 16), sets all weights to 1 and the sum to the count, all registered when
// it is accepted. A pick request first reduces random_value modulo the weight sum in a
// restoring unit that settles one quotient bit per cycle (skipped when the sum is zero),
// then makes one pipelined read-modify-write pass over the n weights in use in the weight
// memory, choosing the entry and aging all others in the same pass. Requests are taken one
// at a time, and a result waiting in the output register does not block the next request.
// depends on awrp_pkg, awrp_if, awrp_mod_unit and awrp_weight_store
`timescale 1ns / 1ps

module aging_weighted_random_picker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [awrp_pkg::CFG_W-1:0]  cfg_wr_data,
    awrp_req_if.sink                    req_in,
    awrp_res_if.source                  res_out
);

    awrp_pkg::state_t                state_reg, state_next;
    logic [awrp_pkg::CFG_W-1:0]      entry_count_reg;
    logic [awrp_pkg::CNT_W-1:0]      active_count_reg, active_count_next;
    logic [awrp_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [awrp_pkg::SUM_W-1:0]      rem_reg, rem_next;
    logic [awrp_pkg::IDX_W-1:0]      issue_idx_reg, issue_idx_next;
    logic                            issue_act_reg, issue_act_next;
    logic                            proc_valid_reg, proc_valid_next;
    logic [awrp_pkg::IDX_W-1:0]      proc_idx_reg, proc_idx_next;
    logic                            found_reg, found_next;
    logic [awrp_pkg::IDX_W-1:0]      sel_reg, sel_next;
    logic                            out_valid_reg, out_valid_next;
    logic [awrp_pkg::IDX_W-1:0]      out_index_reg, out_index_next;

    logic                            req_accept;
    logic                            restart;
    logic                            pick_start;
    logic                            mod_start;
    logic                            mod_done;
    logic [awrp_pkg::SUM_W-1:0]      mod_rem;
    logic                            out_free;
    logic                            load_out;
    logic                            walk_last;
    logic [awrp_pkg::IDX_W-1:0]      last_idx;
    logic [awrp_pkg::CNT_W-1:0]      clamp_count;
    logic [awrp_pkg::WEIGHT_W-1:0]   weight;
    logic                            inc;
    logic [awrp_pkg::WEIGHT_W-1:0]   weight_inc;
    logic                            hit;
    awrp_pkg::ws_rd_req_t            rd_req;
    awrp_pkg::ws_wr_req_t            wr_req;

    assign req_accept = req_in.valid && req_in.ready;
    assign out_free   = !out_valid_reg || res_out.ready;
    assign last_idx   = awrp_pkg::IDX_W'(active_count_reg - 1'b1);
    assign walk_last  = proc_valid_reg && (proc_idx_reg == last_idx);

    // entry count clamped to the supported range
    always_comb
    begin
        if (entry_count_reg == '0)
        begin
            clamp_count = awrp_pkg::CNT_W'(1);
        end
        else if (32'(entry_count_reg) > 32'(awrp_pkg::MAX_ENTRIES))
        begin
            clamp_count = awrp_pkg::CNT_W'(awrp_pkg::MAX_ENTRIES);
        end
        else
        begin
            clamp_count = awrp_pkg::CNT_W'(entry_count_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            awrp_pkg::ST_IDLE:
            begin
                if (req_accept && (req_in.action == awrp_pkg::ACT_PICK))
                begin
                    state_next = (sum_reg == '0) ? awrp_pkg::ST_WALK : awrp_pkg::ST_MOD;
                end
            end
            awrp_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = awrp_pkg::ST_WALK;
                end
            end
            awrp_pkg::ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = awrp_pkg::ST_DONE;
                end
            end
            awrp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = awrp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = awrp_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_in.ready = 1'b0;
        restart      = 1'b0;
        pick_start   = 1'b0;
        mod_start    = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            awrp_pkg::ST_IDLE:
            begin
                req_in.ready = 1'b1;
                restart      = req_accept && (req_in.action == awrp_pkg::ACT_RESTART);
                pick_start   = req_accept && (req_in.action == awrp_pkg::ACT_PICK);
                mod_start    = pick_start && (sum_reg != '0);
            end
            awrp_pkg::ST_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                req_in.ready = 1'b0;
            end
        endcase
    end

    // remainder of the random word
    awrp_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (req_in.random_value),
        .divisor   (sum_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // weight memory
    awrp_weight_store u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (restart),
        .rd        (rd_req),
        .wr        (wr_req),
        .rd_weight (weight)
    );

    // aging of the weight coming back from memory
    assign inc        = (weight != awrp_pkg::WEIGHT_MAX);
    assign weight_inc = weight + awrp_pkg::WEIGHT_W'(inc);
    assign hit        = proc_valid_reg && !found_reg
                        && ((rem_reg < awrp_pkg::SUM_W'(weight)) || (proc_idx_reg == last_idx));

    // walk: issue reads one a cycle, write back the aged weight in the following cycle
    always_comb
    begin
        active_count_next = active_count_reg;
        sum_next          = sum_reg;
        rem_next          = rem_reg;
        issue_idx_next    = issue_idx_reg;
        issue_act_next    = issue_act_reg;
        proc_valid_next   = 1'b0;
        proc_idx_next     = issue_idx_reg;
        found_next        = found_reg;
        sel_next          = sel_reg;
        out_index_next    = out_index_reg;
        out_valid_next    = out_valid_reg && !res_out.ready;

        rd_req.en    = 1'b0;
        rd_req.addr  = issue_idx_reg;
        wr_req.en    = proc_valid_reg;
        wr_req.addr  = proc_idx_reg;
        wr_req.data  = hit ? '0 : weight_inc;

        // restart
        if (restart)
        begin
            active_count_next = clamp_count;
            sum_next          = awrp_pkg::SUM_W'(clamp_count);
        end

        // start of a walk
        if ((pick_start && (sum_reg == '0)) || mod_done)
        begin
            rem_next       = pick_start ? '0 : mod_rem;
            issue_idx_next = '0;
            issue_act_next = 1'b1;
            found_next     = 1'b0;
        end

        // read issue
        if (issue_act_reg)
        begin
            rd_req.en       = 1'b1;
            proc_valid_next = 1'b1;
            if (issue_idx_reg == last_idx)
            begin
                issue_act_next = 1'b0;
            end
            else
            begin
                issue_idx_next = issue_idx_reg + 1'b1;
            end
        end

        // compare, age and write back
        if (proc_valid_reg)
        begin
            sum_next = sum_reg + awrp_pkg::SUM_W'(inc)
                       - (hit ? awrp_pkg::SUM_W'(weight_inc) : '0);
            if (hit)
            begin
                found_next = 1'b1;
                sel_next   = proc_idx_reg;
            end
            else if (!found_reg)
            begin
                rem_next = rem_reg - awrp_pkg::SUM_W'(weight);
            end
        end

        // result register
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_index_next = sel_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= awrp_pkg::ST_IDLE;
            entry_count_reg  <= awrp_pkg::CFG_W'(1);
            active_count_reg <= awrp_pkg::CNT_W'(1);
            sum_reg          <= awrp_pkg::SUM_W'(1);
            issue_act_reg    <= 1'b0;
            proc_valid_reg   <= 1'b0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_count_reg <= active_count_next;
            sum_reg          <= sum_next;
            issue_act_reg    <= issue_act_next;
            proc_valid_reg   <= proc_valid_next;
            found_reg        <= found_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        issue_idx_reg <= issue_idx_next;
        proc_idx_reg  <= proc_idx_next;
        sel_reg       <= sel_next;
        out_index_reg <= out_index_next;
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.chosen_index = out_index_reg;

    // walk starts with a zero sum or with a remainder below the sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == awrp_pkg::ST_WALK) && ($past(state_reg) != awrp_pkg::ST_WALK)
        |-> ((sum_reg == '0) || (rem_reg < sum_reg)))
        else $error("walk started with remainder not below sum");

    // every walk ends with a chosen entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == awrp_pkg::ST_DONE) |-> found_reg)
        else $error("walk finished without a chosen entry");

    // the pass never reaches entries beyond those in use
    assert property (@(posedge clk) disable iff (!rst_n)
        proc_valid_reg |-> (proc_idx_reg <= last_idx))
        else $error("weight pass beyond last entry in use");

    // after a restart the sum equals the entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (sum_reg == awrp_pkg::SUM_W'(active_count_reg)))
        else $error("sum does not match entry count after restart");

endmodule

// File: tb/tb_aging_weighted_random_picker.sv
// testbench for the aging weighted random picker: directed and random restart and pick
// requests with random idling on both channels, checked against a built-in weight tracker
// depends on awrp_pkg, awrp_if and aging_weighted_random_picker
`timescale 1ns / 1ps

// weight tracker: mirrors the weights and their sum, predicts the chosen index of each pick
class pick_tracker;
    logic [awrp_pkg::WEIGHT_W-1:0] weight [awrp_pkg::MAX_ENTRIES];
    logic [63:0]                   weight_total;
    int unsigned                   live_count;
    logic [awrp_pkg::CFG_W-1:0]    count_reg;
    logic [awrp_pkg::IDX_W-1:0]    pending_index [$];
    int                            errors;
    int                            picks;
    int                            restarts;
    int                            zero_sum_picks;
    int                            results_checked;
    int                            count_writes;

    function new();
        errors          = 0;
        picks           = 0;
        restarts        = 0;
        zero_sum_picks  = 0;
        results_checked = 0;
        count_writes    = 0;
        count_reg       = awrp_pkg::CFG_W'(1);
        restart_weights();
    endfunction

    // latch the count (clamped) and set every weight to one
    function void restart_weights();
        int unsigned n;
        n = 32'(count_reg);
        if (n == 0)
            n = 1;
        if (n > awrp_pkg::MAX_ENTRIES)
            n = awrp_pkg::MAX_ENTRIES;
        live_count = n;
        for (int i = 0; i < awrp_pkg::MAX_ENTRIES; i++)
            weight[i] = 1;
        weight_total = 64'(n);
    endfunction

    function void set_entry_count(logic [awrp_pkg::CFG_W-1:0] value);
        count_reg = value;
        count_writes++;
    endfunction

    // accepted request: update the weights and queue the expected index of a pick
    function void take_request(logic act, logic [awrp_pkg::RND_W-1:0] rnd);
        logic [63:0] remainder;
        int unsigned sel;
        bit          found;
        if (act == awrp_pkg::ACT_RESTART) begin
            restarts++;
            restart_weights();
            return;
        end
        picks++;
        remainder = 0;
        if (weight_total != 0)
            remainder = {32'd0, rnd} % weight_total;
        else
            zero_sum_picks++;
        // walk the weights until the remainder falls inside one
        sel   = live_count - 1;
        found = 1'b0;
        for (int j = 0; j < live_count; j++) begin
            if (!found) begin
                if (remainder < {32'd0, weight[j]}) begin
                    sel   = j;
                    found = 1'b1;
                end
                else begin
                    remainder = remainder - {32'd0, weight[j]};
                end
            end
        end
        // age every entry in use, saturating, then clear the chosen one
        for (int j = 0; j < live_count; j++) begin
            if (weight[j] != awrp_pkg::WEIGHT_MAX) begin
                weight[j]    = weight[j] + 1;
                weight_total = weight_total + 1;
            end
        end
        weight_total = weight_total - {32'd0, weight[sel]};
        weight[sel]  = 0;
        pending_index.push_back(sel[awrp_pkg::IDX_W-1:0]);
    endfunction

    // accepted result: compare with the oldest expected index
    function void check_index(logic [awrp_pkg::IDX_W-1:0] actual);
        logic [awrp_pkg::IDX_W-1:0] expected;
        results_checked++;
        if (pending_index.size() == 0) begin
            errors++;
            $display("%0t: result with no pick waiting, chosen_index actual %0d",
                     $time, actual);
            return;
        end
        expected = pending_index.pop_front();
        if (actual !== expected) begin
            errors++;
            $display("%0t: chosen_index mismatch, expected %0d, actual %0d",
                     $time, expected, actual);
        end
    endfunction

    function int pending();
        return pending_index.size();
    endfunction

    // picks whose result never came
    function void report_leftover();
        if (pending_index.size() != 0) begin
            errors += pending_index.size();
            $display("%0t: %0d expected results never arrived, oldest expected %0d",
                     $time, pending_index.size(), pending_index[0]);
        end
    endfunction
endclass

module tb_aging_weighted_random_picker;

    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int MAX_GAP         = 12;
    localparam int LATENCY_WAIT    = 64;
    localparam int LONG_HOLD       = 400;
    localparam int TIMEOUT_NS      = 2_000_000;
    // entry count per random phase, a negative value draws one at random
    localparam int PHASE_SETTING [PHASES] = '{16, 1, 0, 31, 17, 2, 15, -1, -1, 8, 16, 3, -1, 5};

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [awrp_pkg::CFG_W-1:0]   cfg_wr_data;

    bit                           no_idle      = 1'b0;
    bit                           hold_results = 1'b0;

    pick_tracker                  tracker;

    awrp_req_if req_if ();
    awrp_res_if res_if ();

    aging_weighted_random_picker i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_in      (req_if),
        .res_out     (res_if)
    );

    // clock
    always
    begin
        #1 clk = 1'b0;
        #1 clk = 1'b1;
    end

    // run limit
    initial
    begin
        #TIMEOUT_NS;
        $display("timeout after %0d ns, %0d picks still waiting", TIMEOUT_NS, tracker.pending());
        $display("Verification failed");
        $finish;
    end

    // drive one request after a random gap and wait until it is taken
    task automatic send_request(input logic act, input logic [awrp_pkg::RND_W-1:0] rnd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.action       <= act;
        req_if.random_value <= rnd;
        do
            @(posedge clk);
        while (!req_if.ready);
        tracker.take_request(act, rnd);
    endtask

    // stop offering requests until every pick has been answered
    task automatic drain(input int extra);
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_entry_count(input logic [awrp_pkg::CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.set_entry_count(value);
    endtask

    // result side: random stalls, an occasional long hold-off
    initial
    begin : result_side
        int stall;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_if.valid);
            tracker.check_index(res_if.chosen_index);
        end
    end

    // request side: reset, directed requests, random phases, wrap-up
    initial
    begin : request_side
        logic                       act;
        logic [awrp_pkg::RND_W-1:0] word;
        logic [awrp_pkg::CFG_W-1:0] setting;
        int                         sel;

        tracker             = new();
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        req_if.valid        <= 1'b0;
        req_if.action       <= awrp_pkg::ACT_RESTART;
        req_if.random_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // state after reset: one entry, then the zero sum case
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0000);
        send_request(awrp_pkg::ACT_PICK, 32'hFFFF_FFFF);
        drain(LATENCY_WAIT);

        // new count is not used before a restart
        write_entry_count(5'd16);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0007);
        send_request(awrp_pkg::ACT_RESTART, 32'hFFFF_FFFF);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0000);
        send_request(awrp_pkg::ACT_PICK, 32'hFFFF_FFFF);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_000F);
        send_request(awrp_pkg::ACT_PICK, 32'h8000_0000);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0001);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_001E);
        send_request(awrp_pkg::ACT_RESTART, 32'h0000_0000);
        drain(LATENCY_WAIT);

        // count of zero is taken as one
        write_entry_count(5'd0);
        send_request(awrp_pkg::ACT_RESTART, 32'h5A5A_5A5A);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0000);
        send_request(awrp_pkg::ACT_PICK, 32'hFFFF_FFFF);
        drain(LATENCY_WAIT);

        // counts above the slot number are clamped
        write_entry_count(5'd31);
        send_request(awrp_pkg::ACT_RESTART, 32'hA5A5_A5A5);
        send_request(awrp_pkg::ACT_PICK, 32'hFFFF_FFFF);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0000);
        send_request(awrp_pkg::ACT_PICK, 32'h1234_5678);
        drain(LATENCY_WAIT);
        write_entry_count(5'd17);
        send_request(awrp_pkg::ACT_RESTART, 32'h0000_0000);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0010);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0037);
        drain(LATENCY_WAIT);

        // two entries, alternating picks
        write_entry_count(5'd2);
        send_request(awrp_pkg::ACT_RESTART, 32'h0000_0000);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0001);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0001);
        send_request(awrp_pkg::ACT_PICK, 32'h0000_0000);
        drain(LATENCY_WAIT);

        // random phases, one entry count each
        for (int p = 0; p < PHASES; p++)
        begin
            if (PHASE_SETTING[p] < 0)
                setting = awrp_pkg::CFG_W'($urandom_range(0, 31));
            else
                setting = awrp_pkg::CFG_W'(PHASE_SETTING[p]);
            write_entry_count(setting);
            // one phase keeps the previous count latched
            if (p != 5)
                send_request(awrp_pkg::ACT_RESTART, $urandom);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (k % 50 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if (p == 3 && k == 30)
                    hold_results = 1'b1;
                if (p == 6 && k == 60)
                    drain(0);
                act = ($urandom_range(0, 19) == 0) ? awrp_pkg::ACT_RESTART : awrp_pkg::ACT_PICK;
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    word = $urandom;
                else if (sel == 7)
                    word = $urandom_range(0, 64);
                else if (sel == 8)
                    word = '0;
                else
                    word = '1;
                send_request(act, word);
            end
            no_idle = 1'b0;
            drain(LATENCY_WAIT);
        end

        tracker.report_leftover();
        $display("covered %0d picks (%0d on a zero sum) and %0d restarts, %0d results checked",
                 tracker.picks, tracker.zero_sum_picks, tracker.restarts,
                 tracker.results_checked);
        $display("entry count written %0d times, clamped and zero counts included, %0d errors",
                 tracker.count_writes, tracker.errors);
        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
